FILE: hdl/ilp_pkg.sv
package ilp_pkg;

  localparam int unsigned NumberWidthDef = 32;
  localparam int unsigned ValueWidth     = 32;
  localparam int unsigned QueueDepth     = 4;
  localparam int unsigned AddrWidth      = 3;

  localparam logic RegSkipEnable = 1'b0;

  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChSeven   = 8'h37;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChUpperA  = 8'h41;
  localparam logic [7:0] ChUpperF  = 8'h46;
  localparam logic [7:0] ChUpperX  = 8'h58;
  localparam logic [7:0] ChLowerA  = 8'h61;
  localparam logic [7:0] ChLowerF  = 8'h66;
  localparam logic [7:0] ChLowerX  = 8'h78;

  typedef struct packed {
    logic [ValueWidth-1:0] value;
    logic                  status;
    logic                  last;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

FILE: hdl/ilp_front.sv
module ilp_front #(
  parameter int unsigned NumberWidth = ilp_pkg::NumberWidthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           skip_en_i,
  input  logic [7:0]     char_in_i,
  input  logic           end_of_text_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           room_i,
  output ilp_pkg::push_t push_o
);

  localparam int unsigned ExtW = (NumberWidth > ilp_pkg::ValueWidth) ?
                                 NumberWidth : ilp_pkg::ValueWidth;

  typedef enum logic [2:0] {
    MIdle,
    MComment,
    MZero,
    MHexPre,
    MHex,
    MOct,
    MDec
  } mode_e;

  mode_e                  mode_q, mode_d;
  logic [NumberWidth-1:0] acc_q, acc_d, acc_s;
  logic [NumberWidth-1:0] dec_next, hex_next, oct_next;
  logic [ExtW-1:0]        ext_q, ext_s;
  logic                   c_dec, c_oct, c_hex, c_space, c_slash, c_x, c_nl;
  logic [3:0]             hval;
  logic                   take, need_end, do_start, bad, eot_emit;
  ilp_pkg::res_t          ra, rb, rc, first, second;
  logic [1:0]             n;

  assign in_ready_o = room_i;
  assign take       = in_valid_i & room_i;

  // character classes
  always_comb begin
    c_dec   = (char_in_i >= ilp_pkg::ChZero) && (char_in_i <= ilp_pkg::ChNine);
    c_oct   = (char_in_i >= ilp_pkg::ChZero) && (char_in_i <= ilp_pkg::ChSeven);
    c_hex   = c_dec ||
              ((char_in_i >= ilp_pkg::ChLowerA) && (char_in_i <= ilp_pkg::ChLowerF)) ||
              ((char_in_i >= ilp_pkg::ChUpperA) && (char_in_i <= ilp_pkg::ChUpperF));
    c_space = (char_in_i == ilp_pkg::ChSpace) ||
              ((char_in_i >= ilp_pkg::ChTab) && (char_in_i <= ilp_pkg::ChCr));
    c_slash = (char_in_i == ilp_pkg::ChSlash);
    c_x     = (char_in_i == ilp_pkg::ChLowerX) || (char_in_i == ilp_pkg::ChUpperX);
    c_nl    = (char_in_i == ilp_pkg::ChNewline);
    hval    = c_dec ? char_in_i[3:0] : 4'(char_in_i[3:0] + 4'd9);
  end

  assign dec_next = (acc_q << 3) + (acc_q << 1) + NumberWidth'(char_in_i[3:0]);
  assign hex_next = (acc_q << 4) | NumberWidth'(hval);
  assign oct_next = (acc_q << 3) | NumberWidth'(char_in_i[2:0]);

  always_comb begin
    mode_d   = mode_q;
    acc_d    = acc_q;
    need_end = 1'b0;
    do_start = 1'b0;
    bad      = 1'b0;
    case (mode_q)
      MComment: begin
        if (c_nl) mode_d = MIdle;
      end
      MZero: begin
        if (c_x) begin
          mode_d = MHexPre;
        end else if (c_oct) begin
          acc_d  = oct_next;
          mode_d = MOct;
        end else begin
          need_end = 1'b1;
        end
      end
      MHexPre, MHex: begin
        if (c_hex) begin
          acc_d  = hex_next;
          mode_d = MHex;
        end else begin
          need_end = 1'b1;
        end
      end
      MOct: begin
        if (c_oct) acc_d = oct_next;
        else need_end = 1'b1;
      end
      MDec: begin
        if (c_dec) acc_d = dec_next;
        else need_end = 1'b1;
      end
      default: begin
        do_start = 1'b1;
      end
    endcase
    if (need_end) begin
      do_start = 1'b1;
      acc_d    = '0;
      mode_d   = MIdle;
    end
    if (do_start) begin
      if (skip_en_i && c_space) begin
        mode_d = MIdle;
      end else if (skip_en_i && c_slash) begin
        mode_d = MComment;
      end else if (char_in_i == ilp_pkg::ChZero) begin
        acc_d  = '0;
        mode_d = MZero;
      end else if (c_dec) begin
        acc_d  = NumberWidth'(char_in_i[3:0]);
        mode_d = MDec;
      end else begin
        mode_d = MIdle;
        bad    = 1'b1;
      end
    end
    acc_s    = acc_d;
    eot_emit = end_of_text_i && (mode_d != MIdle) && (mode_d != MComment);
    if (end_of_text_i) begin
      acc_d  = '0;
      mode_d = MIdle;
    end
  end

  // result list, at most two per word
  always_comb begin
    ext_q  = ExtW'(acc_q);
    ext_s  = ExtW'(acc_s);
    ra     = '{value: ext_q[ilp_pkg::ValueWidth-1:0], status: 1'b0, last: 1'b0};
    rb     = '{value: '0, status: 1'b1, last: 1'b0};
    rc     = '{value: ext_s[ilp_pkg::ValueWidth-1:0], status: 1'b0, last: 1'b0};
    first  = ra;
    second = rc;
    n      = 2'd0;
    if (need_end) begin
      first = ra;
      if (bad) begin
        second = rb;
        n      = 2'd2;
      end else if (eot_emit) begin
        second = rc;
        n      = 2'd2;
      end else begin
        n = 2'd1;
      end
    end else if (bad) begin
      first = rb;
      n     = 2'd1;
    end else if (eot_emit) begin
      first = rc;
      n     = 2'd1;
    end
    if (n == 2'd1) first.last = 1'b1;
    if (n == 2'd2) second.last = 1'b1;
    push_o.count  = take ? n : 2'd0;
    push_o.first  = first;
    push_o.second = second;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MIdle;
      acc_q  <= '0;
    end else if (take) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
    end
  end

endmodule

FILE: hdl/ilp_rq.sv
module ilp_rq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ilp_pkg::push_t push_i,
  output logic           room_o,
  input  logic           pop_i,
  output logic           not_empty_o,
  output ilp_pkg::res_t  head_o
);

  localparam int unsigned Depth = ilp_pkg::QueueDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = PtrW + 1;

  ilp_pkg::res_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, wr_ptr_p1, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign wr_ptr_p1   = PtrW'(wr_ptr_q + 1'b1);
  assign room_o      = (cnt_q <= CntW'(Depth - 2));
  assign not_empty_o = (cnt_q != '0);
  assign head_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = PtrW'(wr_ptr_q + PtrW'(push_i.count));
    rd_ptr_d = pop_i ? PtrW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    cnt_d    = CntW'(cnt_q + CntW'(push_i.count) - CntW'(pop_i));
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_ptr_q] <= push_i.first;
    if (push_i.count == 2'd2) mem_q[wr_ptr_p1] <= push_i.second;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("result queue overfilled");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |-> room_o)
    else $error("push without room");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> not_empty_o)
    else $error("pop from empty queue");

  a_last_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((push_i.count == 2'd1) |-> push_i.first.last) and
    ((push_i.count == 2'd2) |-> (push_i.second.last && !push_i.first.last)))
    else $error("last flag misplaced");

endmodule

FILE: hdl/ilp_back.sv
module ilp_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               not_empty_i,
  input  ilp_pkg::res_t                      head_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [ilp_pkg::ValueWidth-1:0]     value_o,
  output logic                               status_o,
  output logic                               last_result_o
);

  logic          out_valid_q, out_valid_d;
  ilp_pkg::res_t out_q;

  assign pop_o       = not_empty_i && (!out_valid_q || out_ready_i);
  assign out_valid_d = pop_o || (out_valid_q && !out_ready_i);

  assign out_valid_o   = out_valid_q;
  assign value_o       = out_q.value;
  assign status_o      = out_q.status;
  assign last_result_o = out_q.last;

  always_ff @(posedge clk_i) begin
    if (pop_o) out_q <= head_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: hdl/integer_literal_parser_unit.sv
// Byte-serial parser for C-style unsigned integer literals (decimal, octal with a
// leading 0, hex with 0x/0X). Each input word carries one character; a number ends
// at the first character that cannot extend it, which then starts the next token,
// or at a word marked end_of_text. Words are decoded combinationally by the front
// parser, so a new character is accepted every clock while the four-entry result
// queue has room for two results; a word yields zero, one or two results, the
// final one of a word flagged by last_result_o. Results leave through a registered
// output stage, one per cycle, so the input keeps flowing while the output stalls
// until the queue fills. An invalid start character gives value 0 with status 1.
// skip_enable (register 0, reset 1) drops whitespace and '/' comments up to a
// newline; write it only while the block is idle.
module integer_literal_parser_unit #(
  parameter int unsigned NumberWidth = ilp_pkg::NumberWidthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ilp_pkg::AddrWidth-1:0]    paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  logic [7:0]                       char_in_i,
  input  logic                             end_of_text_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  output logic [ilp_pkg::ValueWidth-1:0]   value_o,
  output logic                             status_o,
  output logic                             last_result_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i
);

  logic           skip_en_q;
  logic           room, pop, not_empty;
  ilp_pkg::push_t push;
  ilp_pkg::res_t  head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ilp_pkg::RegSkipEnable) ? {31'b0, skip_en_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_en_q <= 1'b1;
    end else if (psel && penable && pwrite && (paddr[2] == ilp_pkg::RegSkipEnable)) begin
      skip_en_q <= pwdata[0];
    end
  end

  ilp_front #(
    .NumberWidth(NumberWidth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .skip_en_i    (skip_en_q),
    .char_in_i    (char_in_i),
    .end_of_text_i(end_of_text_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .room_i       (room),
    .push_o       (push)
  );

  ilp_rq u_rq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_o     (room),
    .pop_i      (pop),
    .not_empty_o(not_empty),
    .head_o     (head)
  );

  ilp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .not_empty_i  (not_empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .value_o      (value_o),
    .status_o     (status_o),
    .last_result_o(last_result_o)
  );

endmodule

FILE: tb/ilp_result_checker.sv
module ilp_result_checker
  import ilp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic                  pready_i,
  input  logic [AddrWidth-1:0]  paddr_i,
  input  logic [31:0]           pwdata_i,
  input  logic [7:0]            char_in_i,
  input  logic                  end_of_text_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [ValueWidth-1:0] value_i,
  input  logic                  status_i,
  input  logic                  last_result_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  output int                    error_count_o,
  output int                    pending_o,
  output int                    results_o,
  output int                    invalid_o
);

  typedef enum logic [2:0] {
    ModeIdle,
    ModeComment,
    ModeZero,
    ModeHexPrefix,
    ModeHex,
    ModeOct,
    ModeDec
  } parse_mode_e;

  localparam logic [AddrWidth-1:0] SkipAddr = AddrWidth'(4 * RegSkipEnable);

  logic              skip_q;
  parse_mode_e       mode_q;
  logic [31:0]       number_q;
  res_t              word_results[2];
  int                word_count;
  res_t              parsed_values_q[$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count_o++;
  endtask

  task automatic add_result(input logic [31:0] val, input logic invalid);
    if (word_count < 2) begin
      word_results[word_count].value  = val;
      word_results[word_count].status = invalid;
      word_results[word_count].last   = 1'b0;
      word_count++;
    end
  endtask

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= ChZero && c <= ChNine) return int'(c - ChZero);
    if (c >= ChLowerA && c <= ChLowerF) return int'(c - ChLowerA) + 10;
    if (c >= ChUpperA && c <= ChUpperF) return int'(c - ChUpperA) + 10;
    return -1;
  endfunction

  task automatic begin_token(input logic [7:0] c);
    if (skip_q && (c == ChSpace || (c >= ChTab && c <= ChCr))) begin
      mode_q = ModeIdle;
    end else if (skip_q && c == ChSlash) begin
      mode_q = ModeComment;
    end else if (c == ChZero) begin
      number_q = '0;
      mode_q   = ModeZero;
    end else if (c > ChZero && c <= ChNine) begin
      number_q = 32'(c - ChZero);
      mode_q   = ModeDec;
    end else begin
      mode_q = ModeIdle;
      add_result('0, 1'b1);
    end
  endtask

  task automatic close_number(input logic [7:0] c);
    add_result(number_q, 1'b0);
    number_q = '0;
    mode_q   = ModeIdle;
    begin_token(c);
  endtask

  task automatic parse_char(input logic [7:0] c, input logic eot);
    int h;
    word_count = 0;
    case (mode_q)
      ModeComment: begin
        if (c == ChNewline) mode_q = ModeIdle;
      end
      ModeZero: begin
        if (c == ChLowerX || c == ChUpperX) begin
          mode_q = ModeHexPrefix;
        end else if (c >= ChZero && c <= ChSeven) begin
          number_q = 32'(c - ChZero);
          mode_q   = ModeOct;
        end else begin
          close_number(c);
        end
      end
      ModeHexPrefix, ModeHex: begin
        h = hex_digit(c);
        if (h >= 0) begin
          number_q = number_q * 32'd16 + 32'(h);
          mode_q   = ModeHex;
        end else begin
          close_number(c);
        end
      end
      ModeOct: begin
        if (c >= ChZero && c <= ChSeven) number_q = number_q * 32'd8 + 32'(c - ChZero);
        else close_number(c);
      end
      ModeDec: begin
        if (c >= ChZero && c <= ChNine) number_q = number_q * 32'd10 + 32'(c - ChZero);
        else close_number(c);
      end
      default: begin
        begin_token(c);
      end
    endcase
    if (eot) begin
      if (mode_q >= ModeZero && mode_q <= ModeDec) add_result(number_q, 1'b0);
      number_q = '0;
      mode_q   = ModeIdle;
    end
    if (word_count > 0) word_results[word_count-1].last = 1'b1;
    for (int i = 0; i < word_count; i++) parsed_values_q.push_back(word_results[i]);
  endtask

  task automatic check_result();
    res_t want;
    results_o++;
    if (status_i) invalid_o++;
    if (parsed_values_q.size() == 0) begin
      report_mismatch($sformatf("result %0h with nothing outstanding", value_i));
    end else begin
      want = parsed_values_q.pop_front();
      if (value_i !== want.value)
        report_mismatch($sformatf("value got %0h exp %0h", value_i, want.value));
      if (status_i !== want.status)
        report_mismatch($sformatf("invalid flag got %0b exp %0b", status_i, want.status));
      if (last_result_i !== want.last)
        report_mismatch($sformatf("last flag got %0b exp %0b", last_result_i, want.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q   = 1'b1;
      mode_q   = ModeIdle;
      number_q = '0;
      parsed_values_q.delete();
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == SkipAddr) begin
        skip_q = pwdata_i[0];
      end
      if (in_valid_i && in_ready_i) parse_char(char_in_i, end_of_text_i);
      if (out_valid_i && out_ready_i) check_result();
      pending_o <= parsed_values_q.size();
    end
  end

endmodule

FILE: tb/integer_literal_parser_unit_tb.sv
module integer_literal_parser_unit_tb;
  import ilp_pkg::*;

  localparam int ItemsTarget  = 1750;
  localparam int NumPhases    = 5;
  localparam int SettlePause  = 8;
  localparam int DrainCycles  = 20;
  localparam logic [AddrWidth-1:0] SkipAddr = AddrWidth'(4 * RegSkipEnable);

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [AddrWidth-1:0]  paddr         = '0;
  logic [31:0]           pwdata        = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic [7:0]            char_in_i     = '0;
  logic                  end_of_text_i = 1'b0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_ready_o;
  logic [ValueWidth-1:0] value_o;
  logic                  status_o;
  logic                  last_result_o;
  logic                  out_valid_o;
  logic                  out_ready_i   = 1'b0;

  bit gaps_on = 1'b1;
  int items_sent;
  int chars_sent;
  int error_count;
  int pending;
  int results_seen;
  int invalid_seen;
  int total_errors;

  always #5 clk_i = ~clk_i;

  integer_literal_parser_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .char_in_i     (char_in_i),
    .end_of_text_i (end_of_text_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .value_o       (value_o),
    .status_o      (status_o),
    .last_result_o (last_result_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i)
  );

  ilp_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .pready_i      (pready),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .char_in_i     (char_in_i),
    .end_of_text_i (end_of_text_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .value_i       (value_o),
    .status_i      (status_o),
    .last_result_i (last_result_o),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .error_count_o (error_count),
    .pending_o     (pending),
    .results_o     (results_seen),
    .invalid_o     (invalid_seen)
  );

  always @(posedge clk_i) begin
    out_ready_i <= !gaps_on || ($urandom_range(99) >= 20);
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("status: fail");
    $finish;
  end

  task automatic write_skip(input logic skip);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SkipAddr;
    pwdata  <= {31'($urandom()), skip};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_word(input logic [7:0] ch, input logic eot);
    while (gaps_on && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    char_in_i     <= ch;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (!in_ready_o);
    chars_sent++;
  endtask

  task automatic send_text(input string s, input bit eot_at_end);
    for (int i = 0; i < s.len(); i++) send_word(s[i], eot_at_end && i == s.len() - 1);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettlePause) @(posedge clk_i);
  endtask

  // one random token: mostly well-formed literals, some separators and noise
  task automatic send_token();
    logic [7:0] txt[$];
    logic [7:0] b;
    int         kind;
    int         len;
    int         v;
    bit         counts;
    kind   = $urandom_range(99);
    counts = 1'b1;
    if (kind < 22) begin
      len = ($urandom_range(3) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
      txt.push_back(ChZero + 8'($urandom_range(1, 9)));
      repeat (len - 1) txt.push_back(ChZero + 8'($urandom_range(9)));
    end else if (kind < 36) begin
      txt.push_back(ChZero);
      repeat ($urandom_range(1, 12)) txt.push_back(ChZero + 8'($urandom_range(7)));
      if ($urandom_range(4) == 0) txt.push_back(ChZero + 8'($urandom_range(8, 9)));
    end else if (kind < 52) begin
      txt.push_back(ChZero);
      txt.push_back($urandom_range(1) ? ChLowerX : ChUpperX);
      repeat ($urandom_range(0, 10)) begin
        v = $urandom_range(21);
        if (v < 10) txt.push_back(ChZero + 8'(v));
        else if (v < 16) txt.push_back(ChLowerA + 8'(v - 10));
        else txt.push_back(ChUpperA + 8'(v - 16));
      end
    end else if (kind < 56) begin
      txt.push_back(ChZero);
    end else if (kind < 72) begin
      counts = 1'b0;
      repeat ($urandom_range(1, 3))
        txt.push_back(($urandom_range(4) == 0) ? ChSpace : ChTab + 8'($urandom_range(4)));
    end else if (kind < 80) begin
      counts = 1'b0;
      txt.push_back(ChSlash);
      repeat ($urandom_range(0, 6)) begin
        do b = 8'($urandom_range(255)); while (b == ChNewline);
        txt.push_back(b);
      end
      txt.push_back(ChNewline);
    end else begin
      repeat ($urandom_range(1, 3)) txt.push_back(8'($urandom_range(255)));
    end
    foreach (txt[i]) send_word(txt[i], $urandom_range(99) < 3);
    if (counts) items_sent += txt.size();
  endtask

  initial begin
    logic phase_skip[NumPhases];
    int   phase_end;
    phase_skip = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed words with skipping at its reset value
    send_text("08 ", 1'b0);
    send_text("0xg", 1'b0);
    send_text("0XaF/z\n", 1'b0);
    send_word(8'hFF, 1'b0);
    send_text("0777", 1'b1);
    send_text("9", 1'b1);
    send_text("0", 1'b1);
    wait_idle();

    for (int p = 0; p < NumPhases; p++) begin
      write_skip(phase_skip[p]);
      gaps_on   = (p != 2);
      phase_end = (ItemsTarget * (p + 1)) / NumPhases;
      while (chars_sent < phase_end) send_token();
      send_word(ChNewline, 1'b1);
      wait_idle();
    end
    gaps_on = 1'b1;
    repeat (DrainCycles) @(posedge clk_i);

    total_errors = error_count;
    if (pending != 0) begin
      $display("%0d expected results never arrived", pending);
      total_errors += pending;
    end
    $display("sent %0d characters (%0d in literals or noise) over %0d skip settings",
             chars_sent, items_sent, NumPhases + 1);
    $display("checked %0d results, %0d of them invalid, %0d mismatches",
             results_seen, invalid_seen, error_count);
    if (total_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
